// ----- src/wtb_pkg.sv -----
// shared types and constants for the windowed top/bottom five selector
`default_nettype none
package wtb_pkg;

    localparam int KEEP_COUNT = 5;
    localparam int TEMP_BITS  = 8;
    localparam int RANK_BITS  = 3;
    localparam int SPM_BITS   = 5;
    localparam int MPW_BITS   = 8;
    localparam int SCNT_BITS  = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;
    localparam int LIST_BITS  = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int RUN_LEN    = 2 * KEEP_COUNT;
    localparam int RUN_BITS   = $clog2(RUN_LEN);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS  = 1;
    localparam int QCNT_BITS  = 2;

    localparam logic [SPM_BITS-1:0] SPM_RESET = SPM_BITS'(8);
    localparam logic [SPM_BITS-1:0] SPM_MAX   = SPM_BITS'(16);
    localparam logic [MPW_BITS-1:0] MPW_RESET = MPW_BITS'(60);
    localparam logic [MPW_BITS-1:0] MPW_MIN   = MPW_BITS'(KEEP_COUNT);

    typedef logic signed [TEMP_BITS-1:0] temp_t;
    typedef temp_t [KEEP_COUNT-1:0] list_t;

    localparam temp_t TEMP_MAXV = {1'b0, {(TEMP_BITS-1){1'b1}}};
    localparam temp_t TEMP_MINV = {1'b1, {(TEMP_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SENSORS_PER_MINUTE = 1'b0,
        REG_MINUTES_PER_WINDOW = 1'b1
    } cfg_reg_t;

    // one finished window: both lists ascending
    typedef struct packed {
        list_t lowest;
        list_t highest;
    } snap_t;

    typedef struct packed {
        logic  push;
        snap_t data;
    } q_wr_t;

    typedef struct packed {
        logic  full;
    } q_wr_status_t;

    typedef struct packed {
        logic  valid;
        snap_t data;
    } q_rd_t;

endpackage
`default_nettype wire

// ----- src/wtb_front.sv -----
// front end: reading intake, window counting and parallel compare-insert
`default_nettype none
module wtb_front import wtb_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire temp_t                    s_temp,
    input  wire q_wr_status_t             q_status,
    output q_wr_t                         q_wr
);

    logic [SPM_BITS-1:0]  spm_reg;
    logic [MPW_BITS-1:0]  mpw_reg;
    logic [SCNT_BITS-1:0] scnt_reg, scnt_next;
    logic [MPW_BITS-1:0]  mcnt_reg, mcnt_next;
    list_t                low_reg, low_next, low_ins;
    list_t                high_reg, high_next, high_ins;
    logic [SPM_BITS-1:0]  spm_eff;
    logic [MPW_BITS-1:0]  mpw_eff;
    logic                 accept;
    logic                 minute_end;
    logic                 window_end;

    assign s_tready = aresetn && !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spm_reg <= SPM_RESET;
            mpw_reg <= MPW_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_SENSORS_PER_MINUTE: spm_reg <= cfg_data[SPM_BITS-1:0];
                REG_MINUTES_PER_WINDOW: mpw_reg <= cfg_data[MPW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        spm_eff = spm_reg;
        if (spm_reg == '0) begin
            spm_eff = SPM_BITS'(1);
        end else if (spm_reg > SPM_MAX) begin
            spm_eff = SPM_MAX;
        end
        mpw_eff = (mpw_reg < MPW_MIN) ? MPW_MIN : mpw_reg;
    end

    // compare-insert, all positions at once
    always_comb begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            if ($signed(low_reg[i]) <= $signed(s_temp)) begin
                low_ins[i] = low_reg[i];
            end else if (i > 0 && $signed(low_reg[(i > 0) ? i - 1 : 0]) > $signed(s_temp)) begin
                low_ins[i] = low_reg[(i > 0) ? i - 1 : 0];
            end else begin
                low_ins[i] = s_temp;
            end
            if ($signed(high_reg[i]) >= $signed(s_temp)) begin
                high_ins[i] = high_reg[i];
            end else if (i < KEEP_COUNT - 1 &&
                         $signed(high_reg[(i < KEEP_COUNT - 1) ? i + 1 : i]) < $signed(s_temp)) begin
                high_ins[i] = high_reg[(i < KEEP_COUNT - 1) ? i + 1 : i];
            end else begin
                high_ins[i] = s_temp;
            end
        end
    end

    always_comb begin
        minute_end = ({1'b0, scnt_reg} + SPM_BITS'(1)) >= spm_eff;
        window_end = minute_end && (({1'b0, mcnt_reg} + 9'd1) >= {1'b0, mpw_eff});
        scnt_next  = scnt_reg;
        mcnt_next  = mcnt_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        if (accept) begin
            low_next  = low_ins;
            high_next = high_ins;
            if (!minute_end) begin
                scnt_next = scnt_reg + SCNT_BITS'(1);
            end else begin
                scnt_next = '0;
                if (!window_end) begin
                    mcnt_next = mcnt_reg + MPW_BITS'(1);
                end else begin
                    mcnt_next = '0;
                    low_next  = {KEEP_COUNT{TEMP_MAXV}};
                    high_next = {KEEP_COUNT{TEMP_MINV}};
                end
            end
        end
        q_wr.push         = accept && window_end;
        q_wr.data.lowest  = low_ins;
        q_wr.data.highest = high_ins;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scnt_reg <= '0;
            mcnt_reg <= '0;
            low_reg  <= {KEEP_COUNT{TEMP_MAXV}};
            high_reg <= {KEEP_COUNT{TEMP_MINV}};
        end else begin
            scnt_reg <= scnt_next;
            mcnt_reg <= mcnt_next;
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    a_clear_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.push |=> low_reg[0] == TEMP_MAXV && high_reg[KEEP_COUNT-1] == TEMP_MINV)
        else $error("lists not cleared after report");

    a_lists_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        $signed(low_reg[0]) <= $signed(low_reg[KEEP_COUNT-1]) &&
        $signed(high_reg[0]) <= $signed(high_reg[KEEP_COUNT-1]))
        else $error("kept lists out of order");

endmodule
`default_nettype wire

// ----- src/wtb_queue.sv -----
// two-entry report queue between front and back
`default_nettype none
module wtb_queue import wtb_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire q_wr_t  q_wr,
    output q_wr_status_t q_status,
    input  wire logic   pop,
    output q_rd_t       q_rd
);

    snap_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wptr_reg, rptr_reg;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_pop;

    assign q_status.full = count_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign q_rd.valid    = count_reg != '0;
    assign q_rd.data     = entry_reg[rptr_reg];
    assign do_pop        = pop && q_rd.valid;

    always_comb begin
        count_next = count_reg;
        if (q_wr.push && !do_pop) begin
            count_next = count_reg + QCNT_BITS'(1);
        end else if (do_pop && !q_wr.push) begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            entry_reg[wptr_reg] <= q_wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (q_wr.push) begin
                wptr_reg <= wptr_reg + QPTR_BITS'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + QPTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_wr.push && q_status.full))
        else $error("report pushed into full queue");

endmodule
`default_nettype wire

// ----- src/wtb_back.sv -----
// back end: serialises one queued report into ten output beats
`default_nettype none
module wtb_back import wtb_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire q_rd_t         q_rd,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output temp_t              m_temp,
    output logic               m_from_highest,
    output logic [RANK_BITS-1:0] m_rank,
    output logic               m_last
);

    logic [RUN_BITS-1:0]  idx_reg, idx_next;
    logic                 valid_reg;
    temp_t                temp_reg;
    logic                 hi_reg;
    logic [RANK_BITS-1:0] rank_reg;
    logic                 last_reg;
    logic                 load;
    logic                 is_high;
    logic [RUN_BITS-1:0]  pos;
    temp_t                sel_temp;
    logic                 run_end;

    assign load    = (!valid_reg || m_tready) && q_rd.valid;
    assign is_high = idx_reg >= RUN_BITS'(KEEP_COUNT);
    assign pos     = is_high ? idx_reg - RUN_BITS'(KEEP_COUNT) : idx_reg;
    assign sel_temp = is_high ? q_rd.data.highest[pos[LIST_BITS-1:0]]
                              : q_rd.data.lowest[pos[LIST_BITS-1:0]];
    assign run_end = idx_reg == RUN_BITS'(RUN_LEN - 1);
    assign pop     = load && run_end;

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = run_end ? '0 : idx_reg + RUN_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            temp_reg <= sel_temp;
            hi_reg   <= is_high;
            rank_reg <= RANK_BITS'(pos);
            last_reg <= run_end;
        end
    end

    assign m_tvalid       = valid_reg;
    assign m_temp         = temp_reg;
    assign m_from_highest = hi_reg;
    assign m_rank         = rank_reg;
    assign m_last         = last_reg;

    a_last_is_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_last |-> m_from_highest)
        else $error("last beat not from highest list");

    a_pop_at_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> idx_reg == '0 && valid_reg)
        else $error("report popped away from run end");

endmodule
`default_nettype wire

// ----- src/windowed_top_bottom_five.sv -----
// top level of the windowed top-five / bottom-five selector
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid/s_tready    s_tdata: temperature
//   m_       out        m_tvalid/m_tready    m_tdata: report_temp; m_tuser; m_tlast: last
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one reading per cycle while the queue has room; both lists insert it at once
// a window's last reading queues a report; the back end sends it as ten beats,
// one per cycle while m_tready is high, so output bandwidth sets the long-run rate
// the report queue holds two windows; input stalls only when it is full
// aresetn is synchronous; both readies stay low while it is held;
// lists, counters and config registers return to reset values
`default_nettype none
module windowed_top_bottom_five import wtb_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [TEMP_BITS-1:0]     s_tdata,   // [7:0] temperature
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [TEMP_BITS-1:0]          m_tdata,   // [7:0] report_temp
    output logic [RANK_BITS:0]            m_tuser,   // [0] from_highest, [3:1] rank
    output logic                          m_tlast,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    q_wr_t                q_wr;
    q_wr_status_t         q_status;
    q_rd_t                q_rd;
    logic                 pop;
    temp_t                m_temp;
    logic                 m_from_highest;
    logic [RANK_BITS-1:0] m_rank;

    assign cfg_ready = aresetn;

    wtb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_temp    (temp_t'(s_tdata)),
        .q_status  (q_status),
        .q_wr      (q_wr)
    );

    wtb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_wr     (q_wr),
        .q_status (q_status),
        .pop      (pop),
        .q_rd     (q_rd)
    );

    wtb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_rd           (q_rd),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_temp         (m_temp),
        .m_from_highest (m_from_highest),
        .m_rank         (m_rank),
        .m_last         (m_tlast)
    );

    assign m_tdata = m_temp;
    assign m_tuser = {m_rank, m_from_highest};

endmodule
`default_nettype wire
